### sv/bkl_pkg.sv
// shared types and constants for the bucketed keyword lookup
// no dependencies
package bkl_pkg;

  localparam int NAME_BYTES_DEF  = 8;
  localparam int TABLE_DEPTH_DEF = 256;

  // letter buckets A to Z plus the end marker
  localparam int          BUCKETS    = 27;
  localparam logic [4:0]  END_BUCKET = 5'd26;

  // item modes
  localparam logic [1:0] MODE_ENTRY  = 2'd0;
  localparam logic [1:0] MODE_BUCKET = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;

  // characters
  localparam logic [7:0] CHAR_A   = 8'h41;
  localparam logic [7:0] CHAR_Z   = 8'h5A;
  localparam logic [7:0] CHAR_LA  = 8'h61;
  localparam logic [7:0] CHAR_LZ  = 8'h7A;
  localparam logic [7:0] CASE_GAP = CHAR_LA - CHAR_A;

  // running compare status of one entry
  localparam logic [1:0] CMP_EQ = 2'd0;
  localparam logic [1:0] CMP_LT = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  // token handed from cell to cell along with the entry name
  typedef struct packed {
    logic       valid;
    logic [7:0] slot;
    logic [3:0] elen;
    logic       elig;
    logic [1:0] stat;
  } tok_t;

endpackage

### sv/bucketed_keyword_lookup.sv
// bucketed keyword lookup: load items fill the table, lookup items walk a letter bucket
// throughput: one item at a time, the next is taken once busy drops with the result strobe
// results: loads give none; a rejected lookup strobes done the cycle after start;
//   a walked lookup reads its bucket bounds, then streams the bucket's entries from the table
//   through the compare cells and strobes done once an entry decides or the bucket is exhausted
// reset clears control only; table contents are undefined until written
module bucketed_keyword_lookup #(
  parameter int NAME_BYTES  = bkl_pkg::NAME_BYTES_DEF,
  parameter int TABLE_DEPTH = bkl_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [7:0]  entry_index,
  input  logic [63:0] entry_chars,
  input  logic [3:0]  entry_len,
  input  logic        entry_star,
  input  logic [4:0]  bucket,
  input  logic [8:0]  bucket_start,
  input  logic [63:0] query_chars,
  input  logic [3:0]  query_len,
  output logic        done,
  output logic        found,
  output logic [7:0]  match_index
);

  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NAME_W = NAME_BYTES * 8;
  // slot counter holds both a 9 bit bucket start and the table depth itself
  localparam int SLOT_W = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;
  localparam logic [SLOT_W-1:0] DEPTH_S = SLOT_W'(TABLE_DEPTH);
  localparam logic [3:0]        NB_LEN  = 4'(NAME_BYTES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_BKT  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // ---------------------------------------------------------------
  // item accept and query preparation
  // ---------------------------------------------------------------
  logic       accept;
  logic [7:0] qfold [NAME_BYTES];
  logic [7:0] qbyte [NAME_BYTES];
  logic [3:0] qlen;
  logic       letter_ok;
  logic       reject;
  logic [4:0] first_idx;
  logic [4:0] next_idx;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // fold a..z to upper case, everything else passes unchanged
  always_comb begin
    for (int k = 0; k < NAME_BYTES; k++) begin
      qfold[k] = query_chars[k*8 +: 8];
      if (qfold[k] inside {[bkl_pkg::CHAR_LA:bkl_pkg::CHAR_LZ]}) begin
        qfold[k] = qfold[k] - bkl_pkg::CASE_GAP;
      end
    end
  end

  // query length must be 1 to NAME_BYTES and the first byte a letter; percent sign and all else are rejected
  always_comb begin
    letter_ok = (qfold[0] inside {[bkl_pkg::CHAR_A:bkl_pkg::CHAR_Z]});
    reject    = (query_len == 4'd0) || (query_len > NB_LEN) || !letter_ok;
    first_idx = 5'(qfold[0] - bkl_pkg::CHAR_A);
    next_idx  = first_idx + 5'd1;
  end

  always_ff @(posedge clk) begin
    if (accept && mode == bkl_pkg::MODE_LOOKUP) begin
      qbyte <= qfold;
      qlen  <= query_len;
    end
  end

  // ---------------------------------------------------------------
  // bucket start table: one write port, two registered read ports
  // ---------------------------------------------------------------
  logic [8:0] bkt_mem [bkl_pkg::BUCKETS];
  logic [8:0] bkt_lo;
  logic [8:0] bkt_hi;

  always_ff @(posedge clk) begin
    if (accept && mode == bkl_pkg::MODE_BUCKET && bucket <= bkl_pkg::END_BUCKET) begin
      bkt_mem[bucket] <= bucket_start;
    end
    if (accept && mode == bkl_pkg::MODE_LOOKUP && letter_ok) begin
      bkt_lo <= bkt_mem[first_idx];
      bkt_hi <= bkt_mem[next_idx];
    end
  end

  // bucket end, clipped at the table depth
  logic [SLOT_W-1:0] hi_ext;
  logic [SLOT_W-1:0] end_clip;

  assign hi_ext   = SLOT_W'(bkt_hi);
  assign end_clip = (hi_ext > DEPTH_S) ? DEPTH_S : hi_ext;

  // ---------------------------------------------------------------
  // keyword table
  // ---------------------------------------------------------------
  logic              tbl_wr;
  logic [NAME_W-1:0] rd_name;
  logic [3:0]        rd_len;
  logic              rd_star;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_end;
  logic              issue;
  logic              issue_v;
  logic [7:0]        issue_slot;

  // slots at or above the depth are dropped
  assign tbl_wr = accept && mode == bkl_pkg::MODE_ENTRY && SLOT_W'(entry_index) < DEPTH_S;

  bkl_table #(
    .NAME_BYTES  (NAME_BYTES),
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_wr),
    .wr_addr (IDX_W'(entry_index)),
    .wr_name (entry_chars[NAME_W-1:0]),
    .wr_len  (entry_len),
    .wr_star (entry_star),
    .rd_en   (issue),
    .rd_addr (slot[IDX_W-1:0]),
    .rd_name (rd_name),
    .rd_len  (rd_len),
    .rd_star (rd_star)
  );

  // ---------------------------------------------------------------
  // compare chain: one cell per name byte, one entry enters a cycle
  // ---------------------------------------------------------------
  bkl_pkg::tok_t     tok [NAME_BYTES+1];
  logic [NAME_W-1:0] ent [NAME_BYTES+1];
  logic              flush;

  // eligibility: exact length, or starred entry shorter than the query
  always_comb begin
    tok[0].valid = issue_v;
    tok[0].slot  = issue_slot;
    tok[0].elen  = rd_len;
    tok[0].elig  = (qlen == rd_len) || (qlen > rd_len && rd_star);
    tok[0].stat  = bkl_pkg::CMP_EQ;
  end

  assign ent[0] = rd_name;

  for (genvar g = 0; g < NAME_BYTES; g++) begin : g_cell
    bkl_cell #(
      .NAME_BYTES (NAME_BYTES),
      .POS        (g)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .flush   (flush),
      .qbyte   (qbyte[g]),
      .tok_in  (tok[g]),
      .ent_in  (ent[g]),
      .tok_out (tok[g+1]),
      .ent_out (ent[g+1])
    );
  end

  // ---------------------------------------------------------------
  // walk control and decision at the end of the chain
  // ---------------------------------------------------------------
  logic pipe_busy;
  logic hit;
  logic stop_lt;
  logic exhausted;
  logic decide;

  always_comb begin
    pipe_busy = issue_v;
    for (int k = 1; k <= NAME_BYTES; k++) begin
      pipe_busy = pipe_busy || tok[k].valid;
    end
  end

  always_comb begin
    hit       = tok[NAME_BYTES].valid && tok[NAME_BYTES].elig &&
                tok[NAME_BYTES].stat == bkl_pkg::CMP_EQ;
    // query sorts below an eligible entry: later entries cannot match
    stop_lt   = tok[NAME_BYTES].valid && tok[NAME_BYTES].elig &&
                tok[NAME_BYTES].stat == bkl_pkg::CMP_LT;
    exhausted = (slot >= slot_end) && !pipe_busy;
    decide    = (state == S_WALK) && (hit || stop_lt || exhausted);
    issue     = (state == S_WALK) && (slot < slot_end) && !decide;
    flush     = decide;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && mode == bkl_pkg::MODE_LOOKUP && !reject) begin
          state_next = S_BKT;
        end
      end
      S_BKT:  state_next = S_WALK;
      S_WALK: begin
        if (decide) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issue_v <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      issue_v <= issue;
      done    <= (accept && mode == bkl_pkg::MODE_LOOKUP && reject) || decide;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BKT) begin
      slot     <= SLOT_W'(bkt_lo);
      slot_end <= end_clip;
    end else if (issue) begin
      slot <= slot + SLOT_W'(1);
    end
    if (issue) begin
      issue_slot <= slot[7:0];
    end
    // result registers: not found unless the chain reports a hit
    if (accept && mode == bkl_pkg::MODE_LOOKUP && reject) begin
      found       <= 1'b0;
      match_index <= 8'd0;
    end else if (decide) begin
      found       <= hit;
      match_index <= hit ? tok[NAME_BYTES].slot : 8'd0;
    end
  end

  // ---------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------
  a_lookup_progress: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == bkl_pkg::MODE_LOOKUP) |=> (busy || done))
    else $error("lookup item neither started a walk nor gave a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == S_IDLE)
    else $error("result strobe while a walk is still running");

  a_read_in_walk: assert property (@(posedge clk) disable iff (rst)
    issue_v |-> state == S_WALK)
    else $error("table read in flight outside a walk");

  a_no_result_miss: assert property (@(posedge clk) disable iff (rst)
    (done && !found) |-> match_index == 8'd0)
    else $error("not found result carries a nonzero index");

endmodule

### sv/bkl_table.sv
// keyword table memory: name, length and star per slot, registered read
// depends on nothing but its parameters
module bkl_table #(
  parameter int NAME_BYTES  = 8,
  parameter int TABLE_DEPTH = 256,
  localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int NAME_W     = NAME_BYTES * 8
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [NAME_W-1:0] wr_name,
  input  logic [3:0]        wr_len,
  input  logic              wr_star,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_addr,
  output logic [NAME_W-1:0] rd_name,
  output logic [3:0]        rd_len,
  output logic              rd_star
);

  localparam int WORD_W = NAME_W + 5;

  logic [WORD_W-1:0] mem [TABLE_DEPTH];
  logic [WORD_W-1:0] rd_word;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_star, wr_len, wr_name};
    end
    if (rd_en) begin
      rd_word <= mem[rd_addr];
    end
  end

  assign rd_name = rd_word[NAME_W-1:0];
  assign rd_len  = rd_word[NAME_W+3:NAME_W];
  assign rd_star = rd_word[WORD_W-1];

endmodule

### sv/bkl_cell.sv
// one compare cell: checks one name byte of the entry passing through
// depends on bkl_pkg for the token type and compare codes
module bkl_cell #(
  parameter int NAME_BYTES = 8,
  parameter int POS        = 0,
  localparam int NAME_W    = NAME_BYTES * 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              flush,
  input  logic [7:0]        qbyte,
  input  bkl_pkg::tok_t     tok_in,
  input  logic [NAME_W-1:0] ent_in,
  output bkl_pkg::tok_t     tok_out,
  output logic [NAME_W-1:0] ent_out
);

  localparam logic [3:0] POS_L = 4'(POS);

  bkl_pkg::tok_t tok_next;
  logic [7:0]    ebyte;

  assign ebyte = ent_in[POS*8 +: 8];

  always_comb begin
    tok_next       = tok_in;
    // a flush drops whatever is in flight
    tok_next.valid = tok_in.valid && !flush;
    // first differing byte within the entry length decides
    if (tok_in.stat == bkl_pkg::CMP_EQ && POS_L < tok_in.elen && qbyte != ebyte) begin
      tok_next.stat = (qbyte < ebyte) ? bkl_pkg::CMP_LT : bkl_pkg::CMP_GT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    ent_out <= ent_in;
  end

endmodule
